>>> rtl/lbmc_pkg.sv
// Package for the D2Q9 BGK collision block: beat types, register codes,
// reset values, pipeline latencies and saturation helpers. No dependencies.
package lbmc_pkg;

  typedef struct packed {
    logic signed [31:0] dist_0;
    logic signed [31:0] dist_1;
    logic signed [31:0] dist_2;
    logic signed [31:0] dist_3;
    logic signed [31:0] dist_4;
    logic signed [31:0] dist_5;
    logic signed [31:0] dist_6;
    logic signed [31:0] dist_7;
    logic signed [31:0] dist_8;
    logic        [3:0]  cell_class;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] out_0;
    logic signed [31:0] out_1;
    logic signed [31:0] out_2;
    logic signed [31:0] out_3;
    logic signed [31:0] out_4;
    logic signed [31:0] out_5;
    logic signed [31:0] out_6;
    logic signed [31:0] out_7;
    logic signed [31:0] out_8;
    logic signed [31:0] density;
    logic signed [31:0] vel_row;
    logic signed [31:0] vel_col;
  } out_beat_t;

  localparam logic [2:0] REG_RELAX_RATE  = 3'd0;
  localparam logic [2:0] REG_SOUND_SPEED = 3'd1;
  localparam logic [2:0] REG_WEIGHT_REST = 3'd2;
  localparam logic [2:0] REG_WEIGHT_AXIS = 3'd3;
  localparam logic [2:0] REG_WEIGHT_DIAG = 3'd4;

  localparam logic [29:0] RELAX_RATE_RST  = 30'd268435456;
  localparam logic [29:0] SOUND_SPEED_RST = 30'd154978266;
  localparam logic [28:0] WEIGHT_REST_RST = 29'd119304647;
  localparam logic [28:0] WEIGHT_AXIS_RST = 29'd29826162;
  localparam logic [28:0] WEIGHT_DIAG_RST = 29'd7456540;

  // Quotient bits per divider, and the latencies of the pipelined units.
  localparam int Q_BITS   = 32;
  localparam int DIV_LAT  = Q_BITS + 2;
  localparam int LANE_LAT = 7;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (x > 64'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -64'sd2147483648) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'(x);
    end
    return r;
  endfunction

  // Apply a sign to a quotient magnitude that is already clamped to 2^31.
  function automatic logic signed [31:0] sat_sign(input logic [31:0] mag,
                                                  input logic neg);
    logic signed [31:0] r;
    if (neg) begin
      r = -$signed(mag);
    end else if (mag[31]) begin
      r = 32'sh7FFF_FFFF;
    end else begin
      r = $signed(mag);
    end
    return r;
  endfunction

endpackage

>>> rtl/lbmc_dly.sv
// Enabled delay line that keeps side data in step with the pipeline.
// Depends on nothing.
module lbmc_dly #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d;
      for (int i = 1; i < N; i++) begin
        sr_r[i] <= sr_r[i-1];
      end
    end
  end

  assign q = sr_r[N-1];

endmodule

>>> rtl/lbmc_div.sv
// Pipelined restoring divider, one quotient bit per stage, result clamped
// to 2^31. Depends on lbmc_pkg.
module lbmc_div import lbmc_pkg::*; #(
  parameter int NW = 63,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [31:0]   q_mag
);

  localparam int CW = (NW > DW + Q_BITS) ? NW : DW + Q_BITS;

  logic [NW-1:0]     rem_r [Q_BITS+1];
  logic [DW-1:0]     den_r [Q_BITS];
  logic [Q_BITS-1:0] quo_r [Q_BITS+1];
  logic              ovf_r [Q_BITS+1];
  logic [31:0]       q_r;

  // A quotient of 2^32 or more is flagged up front; it only saturates.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num;
      den_r[0] <= den;
      quo_r[0] <= '0;
      ovf_r[0] <= CW'(num) >= (CW'(den) << Q_BITS);
    end
  end

  for (genvar i = 0; i < Q_BITS; i++) begin : g_step
    localparam int B = Q_BITS - 1 - i;
    logic [CW-1:0] sub;
    logic          ge;
    assign sub = CW'(den_r[i]) << B;
    assign ge  = CW'(rem_r[i]) >= sub;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1] <= ge ? NW'(CW'(rem_r[i]) - sub) : rem_r[i];
        quo_r[i+1] <= quo_r[i] | (ge ? (Q_BITS'(1) << B) : '0);
        ovf_r[i+1] <= ovf_r[i];
      end
    end
    if (i < Q_BITS - 1) begin : g_den
      always_ff @(posedge clk) begin
        if (en) begin
          den_r[i+1] <= den_r[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= (ovf_r[Q_BITS] || quo_r[Q_BITS][31]) ? 32'h8000_0000
                                                 : 32'(quo_r[Q_BITS]);
    end
  end

  assign q_mag = q_r;

endmodule

>>> rtl/lbmc_lane.sv
// One direction lane: equilibrium from velocity terms, then relaxation of
// the distribution toward it. Depends on lbmc_pkg.
module lbmc_lane import lbmc_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] usq,
  input  logic        [31:0] cu_mag,
  input  logic               cu_neg,
  input  logic signed [31:0] rho,
  input  logic        [28:0] wgt,
  input  logic        [29:0] omega,
  input  logic signed [31:0] f,
  input  logic               nz,
  output logic signed [31:0] res
);

  logic signed [31:0] cu1_r, usq1_r, rho1_r, f1_r;
  logic               nz1_r;
  logic signed [63:0] cusq_r, rwp_r;
  logic signed [31:0] cu2_r, usq2_r, f2_r;
  logic               nz2_r;
  logic signed [31:0] br_r, rw_r, f3_r;
  logic               nz3_r;
  logic signed [63:0] prod_r;
  logic signed [31:0] f4_r;
  logic               nz4_r;
  logic signed [32:0] d_r;
  logic signed [31:0] f5_r;
  logic               nz5_r;
  logic signed [63:0] p2_r;
  logic signed [31:0] f6_r;
  logic               nz6_r;
  logic signed [31:0] res_r;
  logic signed [35:0] br_sum;
  logic signed [31:0] feq;

  assign br_sum = 36'(cu2_r) + 36'sd268435456 - 36'(usq2_r)
                + $signed({2'b00, cusq_r[62:29]});
  assign feq    = sat32(prod_r >>> 28);

  always_ff @(posedge clk) begin
    if (en) begin
      cu1_r  <= sat_sign(cu_mag, cu_neg);
      usq1_r <= usq;
      rho1_r <= rho;
      f1_r   <= f;
      nz1_r  <= nz;

      cusq_r <= cu1_r * cu1_r;
      rwp_r  <= rho1_r * $signed({1'b0, wgt});
      cu2_r  <= cu1_r;
      usq2_r <= usq1_r;
      f2_r   <= f1_r;
      nz2_r  <= nz1_r;

      br_r   <= sat32(64'(br_sum));
      rw_r   <= sat32(rwp_r >>> 28);
      f3_r   <= f2_r;
      nz3_r  <= nz2_r;

      prod_r <= rw_r * br_r;
      f4_r   <= f3_r;
      nz4_r  <= nz3_r;

      d_r    <= 33'(feq) - 33'(f4_r);
      f5_r   <= f4_r;
      nz5_r  <= nz4_r;

      p2_r   <= $signed({1'b0, omega}) * d_r;
      f6_r   <= f5_r;
      nz6_r  <= nz5_r;

      res_r  <= nz6_r ? sat32(64'(f6_r) + (p2_r >>> 28)) : f6_r;
    end
  end

  assign res = res_r;

endmodule

>>> rtl/lattice_cell_bgk_collision.sv
// Top level of the D2Q9 BGK collision pipeline for one lattice cell per beat.
// Depends on lbmc_pkg, lbmc_dly, lbmc_div and lbmc_lane.
//
//   channel   direction  handshake           payload
//   in_*      input      in_valid/in_stall   in_beat_t  (nine dists, class)
//   out_*     output     out_valid/out_stall out_beat_t (nine dists, moments)
//   cfg_*     input      cfg_we              cfg_idx, cfg_wdata
//
// The block takes one cell per clock while in_stall is low, and the pipeline
// can be fully occupied. The latency to the output register is set mostly
// by two 34-stage pipelined divider chains in series, one quotient bit per
// stage (velocity, then the equilibrium terms), plus the seven-stage lanes.
// Reset is synchronous and active low; it clears the valid chain and the output
// valid, and loads the configuration registers with their reset values.
// The whole pipeline holds only while the last stage has a result that the
// output register cannot hand on, so bubbles never stall the input.
module lattice_cell_bgk_collision import lbmc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [29:0] cfg_wdata
);

  // Timeline, counted from the moment stage B holds the moments.
  localparam int T_LANE_IN = 2 * DIV_LAT + 3;
  localparam int T_LANE    = T_LANE_IN + LANE_LAT;
  localparam int VLD_LEN   = T_LANE + 2;
  localparam int DLY_OUT   = T_LANE - (DIV_LAT + 1);

  typedef struct packed {
    logic signed [31:0] rho;
    logic               col;
    logic               nz;
    logic               vr_neg;
    logic               vc_neg;
  } side_c_t;

  typedef struct packed {
    logic [8:0][31:0]   f;
    logic signed [31:0] rho;
    logic               nz;
  } side_l_t;

  typedef struct packed {
    logic vr_neg;
    logic vc_neg;
    logic p_neg;
    logic m_neg;
  } sign_t;

  typedef struct packed {
    logic signed [31:0] density;
    logic signed [31:0] vel_row;
    logic signed [31:0] vel_col;
  } mom_t;

  // Configuration registers and the squared sound speed derived from them.
  logic [29:0] relax_rate_r, sound_speed_r;
  logic [28:0] weight_rest_r, weight_axis_r, weight_diag_r;
  logic [59:0] cs_sq_r;
  logic [31:0] cs2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relax_rate_r  <= RELAX_RATE_RST;
      sound_speed_r <= SOUND_SPEED_RST;
      weight_rest_r <= WEIGHT_REST_RST;
      weight_axis_r <= WEIGHT_AXIS_RST;
      weight_diag_r <= WEIGHT_DIAG_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_RELAX_RATE:  relax_rate_r  <= cfg_wdata;
        REG_SOUND_SPEED: sound_speed_r <= cfg_wdata;
        REG_WEIGHT_REST: weight_rest_r <= cfg_wdata[28:0];
        REG_WEIGHT_AXIS: weight_axis_r <= cfg_wdata[28:0];
        REG_WEIGHT_DIAG: weight_diag_r <= cfg_wdata[28:0];
        default: ;
      endcase
    end
  end

  // The squared sound speed is never below one LSB.
  always_ff @(posedge clk) begin
    cs_sq_r <= sound_speed_r * sound_speed_r;
    cs2_r   <= (cs_sq_r[59:28] == '0) ? 32'd1 : cs_sq_r[59:28];
  end

  // Flow control: the pipeline moves unless a finished result is blocked.
  // The output register loads whenever it is empty or being taken.
  logic               en;
  logic               out_ld;
  logic [VLD_LEN-1:0] vld_r;
  logic               out_valid_r;
  out_beat_t          out_r;

  assign en       = !(out_valid_r && out_stall && vld_r[VLD_LEN-1]);
  assign out_ld   = !out_valid_r || !out_stall;
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (en) begin
        vld_r <= {vld_r[VLD_LEN-2:0], in_valid};
      end
      if (out_ld) begin
        out_valid_r <= vld_r[VLD_LEN-1];
      end
    end
  end

  // Stage A registers the beat; stage B forms density and momentum.
  in_beat_t           a_dat_r;
  logic signed [35:0] sum, mr, mc;
  logic signed [31:0] rho_sat;
  logic [34:0]        b_mrm_r, b_mcm_r;
  logic               b_mrn_r, b_mcn_r;
  logic signed [31:0] b_rho_r;
  logic [31:0]        b_rhom_r;
  logic               b_col_r, b_nz_r;
  logic [8:0][31:0]   a_f;

  assign a_f = {a_dat_r.dist_8, a_dat_r.dist_7, a_dat_r.dist_6, a_dat_r.dist_5,
                a_dat_r.dist_4, a_dat_r.dist_3, a_dat_r.dist_2, a_dat_r.dist_1,
                a_dat_r.dist_0};

  always_comb begin
    sum = '0;
    for (int k = 0; k < 9; k++) begin
      sum = sum + 36'($signed(a_f[k]));
    end
    mr = 36'(a_dat_r.dist_1) + 36'(a_dat_r.dist_5) + 36'(a_dat_r.dist_8)
       - 36'(a_dat_r.dist_3) - 36'(a_dat_r.dist_6) - 36'(a_dat_r.dist_7);
    mc = 36'(a_dat_r.dist_2) + 36'(a_dat_r.dist_5) + 36'(a_dat_r.dist_6)
       - 36'(a_dat_r.dist_4) - 36'(a_dat_r.dist_7) - 36'(a_dat_r.dist_8);
    rho_sat = sat32(64'(sum));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_dat_r  <= in_data;
      b_rho_r  <= rho_sat;
      b_rhom_r <= rho_sat[31] ? 32'(-rho_sat) : 32'(rho_sat);
      b_mrm_r  <= mr[35] ? 35'(-mr) : 35'(mr);
      b_mcm_r  <= mc[35] ? 35'(-mc) : 35'(mc);
      b_mrn_r  <= mr[35];
      b_mcn_r  <= mc[35];
      // Classes one to four are fluid; a zero sum means no collision.
      b_col_r  <= (a_dat_r.cell_class >= 4'd1) && (a_dat_r.cell_class <= 4'd4);
      b_nz_r   <= (a_dat_r.cell_class >= 4'd1) && (a_dat_r.cell_class <= 4'd4)
                  && (sum != '0);
    end
  end

  // Velocity: momentum scaled by 2^28 over density, in two divider chains.
  logic [31:0] qr_mag, qc_mag;

  lbmc_div #(.NW(63), .DW(32)) u_div_vr (
    .clk(clk), .en(en), .num({b_mrm_r, 28'd0}), .den(b_rhom_r), .q_mag(qr_mag)
  );
  lbmc_div #(.NW(63), .DW(32)) u_div_vc (
    .clk(clk), .en(en), .num({b_mcm_r, 28'd0}), .den(b_rhom_r), .q_mag(qc_mag)
  );

  side_c_t side_b, side_c;
  assign side_b = '{rho: b_rho_r, col: b_col_r, nz: b_nz_r,
                    vr_neg: b_mrn_r ^ b_rho_r[31], vc_neg: b_mcn_r ^ b_rho_r[31]};

  lbmc_dly #(.W($bits(side_c_t)), .N(DIV_LAT)) u_dly_c (
    .clk(clk), .en(en), .d(side_b), .q(side_c)
  );

  // The distributions are carried from stage B, so they are staged once.
  logic [8:0][31:0] a_f_b;
  always_ff @(posedge clk) begin
    if (en) begin
      a_f_b <= a_f;
    end
  end

  side_l_t side_lb, side_l;
  assign side_lb = '{f: a_f_b, rho: b_rho_r, nz: b_nz_r};

  lbmc_dly #(.W($bits(side_l_t)), .N(T_LANE_IN)) u_dly_l (
    .clk(clk), .en(en), .d(side_lb), .q(side_l)
  );

  // Stage C: signed velocities, and the moments as they will be reported.
  logic signed [31:0] c_vr_r, c_vc_r;
  mom_t               c_mom_r, o_mom;
  logic signed [31:0] vr_now, vc_now;

  assign vr_now = sat_sign(qr_mag, side_c.vr_neg);
  assign vc_now = sat_sign(qc_mag, side_c.vc_neg);

  always_ff @(posedge clk) begin
    if (en) begin
      c_vr_r          <= vr_now;
      c_vc_r          <= vc_now;
      c_mom_r.density <= side_c.col ? side_c.rho : 32'sd0;
      c_mom_r.vel_row <= side_c.nz ? vr_now : 32'sd0;
      c_mom_r.vel_col <= side_c.nz ? vc_now : 32'sd0;
    end
  end

  lbmc_dly #(.W($bits(mom_t)), .N(DLY_OUT)) u_dly_o (
    .clk(clk), .en(en), .d(c_mom_r), .q(o_mom)
  );

  // Stage D squares the velocities and forms the sum and difference;
  // stage E adds the squares.
  logic        [62:0] d_vr2_r, d_vc2_r;
  logic        [31:0] d_am_r, d_bm_r;
  logic        [32:0] d_pm_r, d_mm_r;
  sign_t              d_sg_r, e_sg_r, l_sg;
  logic signed [32:0] p_sum, m_dif;
  logic signed [63:0] vr2, vc2;
  logic        [63:0] e_vsq_r;
  logic        [31:0] e_am_r, e_bm_r;
  logic        [32:0] e_pm_r, e_mm_r;

  assign p_sum = 33'(c_vr_r) + 33'(c_vc_r);
  assign m_dif = 33'(c_vr_r) - 33'(c_vc_r);
  assign vr2   = c_vr_r * c_vr_r;
  assign vc2   = c_vc_r * c_vc_r;

  always_ff @(posedge clk) begin
    if (en) begin
      d_vr2_r <= vr2[62:0];
      d_vc2_r <= vc2[62:0];
      d_am_r  <= c_vr_r[31] ? 32'(-c_vr_r) : 32'(c_vr_r);
      d_bm_r  <= c_vc_r[31] ? 32'(-c_vc_r) : 32'(c_vc_r);
      d_pm_r  <= p_sum[32] ? 33'(-p_sum) : 33'(p_sum);
      d_mm_r  <= m_dif[32] ? 33'(-m_dif) : 33'(m_dif);
      d_sg_r  <= '{vr_neg: c_vr_r[31], vc_neg: c_vc_r[31],
                   p_neg: p_sum[32], m_neg: m_dif[32]};
      e_vsq_r <= 64'(d_vr2_r) + 64'(d_vc2_r);
      e_am_r  <= d_am_r;
      e_bm_r  <= d_bm_r;
      e_pm_r  <= d_pm_r;
      e_mm_r  <= d_mm_r;
      e_sg_r  <= d_sg_r;
    end
  end

  // Second divider rank: the velocity square term and the four distinct
  // projections of the velocity onto the lattice directions.
  logic [31:0] q_usq, q_a, q_b, q_p, q_m;

  lbmc_div #(.NW(64), .DW(33)) u_div_usq (
    .clk(clk), .en(en), .num(e_vsq_r), .den({cs2_r, 1'b0}), .q_mag(q_usq)
  );
  lbmc_div #(.NW(60), .DW(32)) u_div_a (
    .clk(clk), .en(en), .num({e_am_r, 28'd0}), .den(cs2_r), .q_mag(q_a)
  );
  lbmc_div #(.NW(60), .DW(32)) u_div_b (
    .clk(clk), .en(en), .num({e_bm_r, 28'd0}), .den(cs2_r), .q_mag(q_b)
  );
  lbmc_div #(.NW(61), .DW(32)) u_div_p (
    .clk(clk), .en(en), .num({e_pm_r, 28'd0}), .den(cs2_r), .q_mag(q_p)
  );
  lbmc_div #(.NW(61), .DW(32)) u_div_m (
    .clk(clk), .en(en), .num({e_mm_r, 28'd0}), .den(cs2_r), .q_mag(q_m)
  );

  lbmc_dly #(.W($bits(sign_t)), .N(DIV_LAT)) u_dly_s (
    .clk(clk), .en(en), .d(e_sg_r), .q(l_sg)
  );

  // Lane inputs. Direction order: rest, (1,0), (0,1), (-1,0), (0,-1),
  // (1,1), (-1,1), (-1,-1), (1,-1). A reversed direction flips the sign.
  logic [31:0]        ln_mag [9];
  logic               ln_neg [9];
  logic [28:0]        ln_w   [9];
  logic signed [31:0] ln_res [9];
  logic signed [31:0] usq_s;

  assign usq_s = sat_sign(q_usq, 1'b0);

  always_comb begin
    ln_mag[0] = '0;   ln_neg[0] = 1'b0;
    ln_mag[1] = q_a;  ln_neg[1] = l_sg.vr_neg;
    ln_mag[2] = q_b;  ln_neg[2] = l_sg.vc_neg;
    ln_mag[3] = q_a;  ln_neg[3] = !l_sg.vr_neg;
    ln_mag[4] = q_b;  ln_neg[4] = !l_sg.vc_neg;
    ln_mag[5] = q_p;  ln_neg[5] = l_sg.p_neg;
    ln_mag[6] = q_m;  ln_neg[6] = !l_sg.m_neg;
    ln_mag[7] = q_p;  ln_neg[7] = !l_sg.p_neg;
    ln_mag[8] = q_m;  ln_neg[8] = l_sg.m_neg;
    for (int k = 0; k < 9; k++) begin
      ln_w[k] = (k == 0) ? weight_rest_r : ((k <= 4) ? weight_axis_r : weight_diag_r);
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_lane
    lbmc_lane u_lane (
      .clk(clk), .en(en), .usq(usq_s), .cu_mag(ln_mag[k]), .cu_neg(ln_neg[k]),
      .rho(side_l.rho), .wgt(ln_w[k]), .omega(relax_rate_r),
      .f($signed(side_l.f[k])), .nz(side_l.nz), .res(ln_res[k])
    );
  end

  // Output register: gathers the lanes and the delayed moments. It holds
  // its beat while the receiver stalls, even when the pipeline moves on.
  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_r <= '{out_0: ln_res[0], out_1: ln_res[1], out_2: ln_res[2],
                 out_3: ln_res[3], out_4: ln_res[4], out_5: ln_res[5],
                 out_6: ln_res[6], out_7: ln_res[7], out_8: ln_res[8],
                 density: o_mom.density, vel_row: o_mom.vel_row,
                 vel_col: o_mom.vel_col};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // The input is held back only by a blocked result in the last stage.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && vld_r[VLD_LEN-1]))
    else $error("input stalled without a blocked result");

  // An accepted beat enters the valid chain.
  a_accept_tracked: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[0])
    else $error("accepted beat lost from the valid chain");

  // A new result only appears from an occupied last stage.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(vld_r[VLD_LEN-1]))
    else $error("result appeared without an item behind it");

endmodule
